// ===== src/b64ld_pkg.sv =====
// Shared types and constants for the lenient Base64 decoder.
package b64ld_pkg;

  localparam logic [6:0] SEXTET_PAD  = 7'd64;
  localparam logic [6:0] SEXTET_SKIP = 7'd65;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;
  localparam logic [7:0] CHAR_EQUAL = 8'h3D;

  typedef struct packed {
    logic [23:0] group_bits;
    logic [1:0]  n_res;
    logic        has_bytes;
    logic        eom;
  } burst_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] s;
    s = SEXTET_SKIP;
    if (ch >= 8'h41 && ch <= 8'h5A) s = 7'(ch - 8'h41);
    else if (ch >= 8'h61 && ch <= 8'h7A) s = 7'(ch - 8'h61 + 8'd26);
    else if (ch >= 8'h30 && ch <= 8'h39) s = 7'(ch - 8'h30 + 8'd52);
    else if (ch == CHAR_PLUS || ch == CHAR_MINUS) s = 7'd62;
    else if (ch == CHAR_SLASH || ch == CHAR_UNDER) s = 7'd63;
    else if (ch == CHAR_EQUAL) s = SEXTET_PAD;
    return s;
  endfunction

endpackage

// ===== src/b64ld_if.sv =====
// Stream interfaces for the character input and the decoded result channel.
interface b64ld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       final_char;
  modport source (output valid, output text_char, output final_char, input ready);
  modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

interface b64ld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       run_end;
  logic       end_of_message;
  modport source (output valid, output data_byte, output byte_valid, output run_end,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input run_end,
                  input end_of_message, output ready);
endinterface

// ===== src/b64ld_group.sv =====
// Sextet gathering state and group decode for one accepted character word.
module b64ld_group
  import b64ld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [7:0] text_char,
  input  logic       final_char,
  output burst_t     burst
);

  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [2:0]  pad_r, pad_nxt;

  logic [6:0]  s;
  logic        sym, is_pad;
  logic [23:0] acc1, flush_acc, emit_acc;
  logic [2:0]  pad1, emit_pad;
  logic [2:0]  cnt1;
  logic        full, flush, emit;
  logic [1:0]  nbytes;

  always_comb begin
    s      = sextet_of(text_char);
    sym    = (s != SEXTET_SKIP);
    is_pad = (s == SEXTET_PAD);
    acc1   = sym ? {acc_r[17:0], (is_pad ? 6'd0 : s[5:0])} : acc_r;
    pad1   = pad_r + {2'd0, sym && is_pad};
    cnt1   = {1'b0, cnt_r} + {2'd0, sym};
    full   = (cnt1 == 3'd4);
    flush  = final_char && !full && (cnt1 != 3'd0);

    unique case (cnt1[1:0])
      2'd1:    flush_acc = {acc1[5:0], 18'd0};
      2'd2:    flush_acc = {acc1[11:0], 12'd0};
      2'd3:    flush_acc = {acc1[17:0], 6'd0};
      default: flush_acc = acc1;
    endcase

    emit     = full || flush;
    emit_acc = full ? acc1 : flush_acc;
    emit_pad = full ? pad1 : 3'(pad1 + (3'd4 - cnt1));
    nbytes   = (emit && emit_pad < 3'd3) ? 2'(3'd3 - emit_pad) : 2'd0;

    burst.group_bits = emit_acc;
    burst.has_bytes  = (nbytes != 2'd0);
    burst.eom        = final_char;
    burst.n_res      = (final_char && nbytes == 2'd0) ? 2'd1 : nbytes;

    if (full || final_char) begin
      acc_nxt = 24'd0;
      cnt_nxt = 2'd0;
      pad_nxt = 3'd0;
    end else begin
      acc_nxt = acc1;
      cnt_nxt = cnt1[1:0];
      pad_nxt = pad1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 24'd0;
      cnt_r <= 2'd0;
      pad_r <= 3'd0;
    end else if (load) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      pad_r <= pad_nxt;
    end
  end

endmodule

// ===== src/b64ld_serializer.sv =====
// Result register that hands out the words of one decoded group in order.
module b64ld_serializer
  import b64ld_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  burst_t burst,
  output logic   can_load,
  b64ld_out_if.source out_ch
);

  logic [23:0] bits_r;
  logic [1:0]  rem_r, idx_r;
  logic        has_r, eom_r;
  logic        pop, take;

  assign pop      = out_ch.valid && out_ch.ready;
  assign can_load = (rem_r == 2'd0) || (pop && rem_r == 2'd1);
  assign take     = load && (burst.n_res != 2'd0);

  always_comb begin
    out_ch.valid          = (rem_r != 2'd0);
    out_ch.byte_valid     = has_r;
    out_ch.run_end        = (rem_r == 2'd1);
    out_ch.end_of_message = eom_r && (rem_r == 2'd1);
    case (idx_r)
      2'd0:    out_ch.data_byte = bits_r[23:16];
      2'd1:    out_ch.data_byte = bits_r[15:8];
      2'd2:    out_ch.data_byte = bits_r[7:0];
      default: out_ch.data_byte = 8'd0;
    endcase
    if (!has_r) out_ch.data_byte = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      idx_r <= 2'd0;
      has_r <= 1'b0;
      eom_r <= 1'b0;
    end else if (take) begin
      rem_r <= burst.n_res;
      idx_r <= 2'd0;
      has_r <= burst.has_bytes;
      eom_r <= burst.eom;
    end else if (pop) begin
      rem_r <= rem_r - 2'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) bits_r <= burst.group_bits;
  end

endmodule

// ===== src/base64_lenient_decoder.sv =====
// Top level of the lenient Base64 decoder.
// Accepts one character word per cycle while ready, standard or URL-safe
// alphabet, skipping any other byte. A completed or flushed group yields up to
// three result words from the result register, one per cycle while the output
// is ready; a character word is accepted in the same cycle as the last word of
// the previous group leaves, so characters giving at most one word then flow at
// one per cycle, and a three-byte group holds the input until its words leave.
// A final character always yields at least one word, marked end_of_message.
module base64_lenient_decoder
  import b64ld_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  b64ld_in_if.sink    in_ch,
  b64ld_out_if.source out_ch
);

  burst_t burst;
  logic   can_load;
  logic   accept;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  b64ld_group u_group (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .text_char  (in_ch.text_char),
    .final_char (in_ch.final_char),
    .burst      (burst)
  );

  b64ld_serializer u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .burst    (burst),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

// ===== tb/base64_lenient_decoder_tb.sv =====
// Self-checking testbench for the lenient Base64 decoder, with its own decode predictor.
module base64_lenient_decoder_tb
  import b64ld_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int IDLE_PCT    = 30;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_end;
    logic       end_of_message;
  } byte_word_t;

  logic clk;
  logic rst_n;

  b64ld_in_if  in_bus();
  b64ld_out_if out_bus();

  base64_lenient_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  byte_word_t  expected_words[$];
  byte_word_t  want_word;
  logic [23:0] grp_bits;
  logic [1:0]  grp_sextets;
  logic [2:0]  grp_pads;
  int          fail_count;
  int          chars_sent;
  int          words_checked;
  int          messages_sent;
  int          stall_cycles;
  bit          steady_flow;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [6:0] char_sextet(input logic [7:0] ch);
    if (ch inside {["A":"Z"]}) return 7'(ch - "A");
    if (ch inside {["a":"z"]}) return 7'(ch - "a" + 26);
    if (ch inside {["0":"9"]}) return 7'(ch - "0" + 52);
    if (ch == CHAR_PLUS || ch == CHAR_MINUS) return 7'd62;
    if (ch == CHAR_SLASH || ch == CHAR_UNDER) return 7'd63;
    if (ch == CHAR_EQUAL) return SEXTET_PAD;
    return SEXTET_SKIP;
  endfunction

  function automatic logic [7:0] pick_b64_char();
    int k;
    k = $urandom_range(0, 63);
    if (k < 26) return 8'("A" + k);
    if (k < 52) return 8'("a" + k - 26);
    if (k < 62) return 8'("0" + k - 52);
    if (k == 62) return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
    return $urandom_range(0, 1) ? CHAR_SLASH : CHAR_UNDER;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic predict_decode(input logic [7:0] ch, input logic fin);
    logic [6:0]  sx;
    logic [23:0] flush_bits;
    int          flush_pads;
    int          missing;
    int          n_words;
    bit          flush;
    byte_word_t  burst[3];
    sx         = char_sextet(ch);
    flush      = 1'b0;
    flush_bits = '0;
    flush_pads = 0;
    n_words    = 0;
    if (sx != SEXTET_SKIP) begin
      grp_bits = {grp_bits[17:0], (sx == SEXTET_PAD) ? 6'd0 : sx[5:0]};
      if (sx == SEXTET_PAD) grp_pads = grp_pads + 3'd1;
      if (grp_sextets == 2'd3) begin
        flush      = 1'b1;
        flush_bits = grp_bits;
        flush_pads = int'(grp_pads);
        {grp_bits, grp_sextets, grp_pads} = '0;
      end else begin
        grp_sextets = grp_sextets + 2'd1;
      end
    end
    if (fin) begin
      // A partial group is completed with zero sextets that count as padding.
      if (grp_sextets != 2'd0) begin
        missing    = 4 - int'(grp_sextets);
        flush      = 1'b1;
        flush_bits = grp_bits << (6 * missing);
        flush_pads = int'(grp_pads) + missing;
      end
      {grp_bits, grp_sextets, grp_pads} = '0;
    end
    if (flush && flush_pads < 3) n_words = 3 - flush_pads;
    for (int i = 0; i < n_words; i++) begin
      burst[i] = '{8'(flush_bits >> (16 - 8 * i)), 1'b1, 1'b0, 1'b0};
    end
    if (fin && n_words == 0) begin
      burst[0] = '0;
      n_words  = 1;
    end
    if (fin) burst[n_words - 1].end_of_message = 1'b1;
    if (n_words > 0) burst[n_words - 1].run_end = 1'b1;
    for (int i = 0; i < n_words; i++) expected_words.push_back(burst[i]);
  endtask

  task automatic send_char(input logic [7:0] ch, input logic fin);
    @(negedge clk);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid      = 1'b1;
    in_bus.text_char  = ch;
    in_bus.final_char = fin;
    do @(posedge clk); while (!in_bus.ready);
    predict_decode(ch, fin);
    chars_sent++;
    if (fin) messages_sent++;
  endtask

  task automatic send_text(input string s, input logic fin_on_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], fin_on_last && (i == s.len() - 1));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_alphabet_extremes();
    send_char(8'h00, 1'b0);
    send_text("Az09", 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("+-/_", 1'b0);
  endtask

  task automatic test_padding_rules();
    send_text("=Z==", 1'b0);
    send_text("====", 1'b0);
    send_text("a=Q9", 1'b0);
  endtask

  task automatic test_final_flush();
    send_char(8'h80, 1'b1);
    send_text("TW", 1'b1);
  endtask

  task automatic test_random_messages(input int n_items);
    int         first_char;
    int         done;
    int         mode;
    int         n_data;
    int         n_pad;
    int         total;
    int         n_msgs;
    logic [7:0] ch;
    first_char = chars_sent;
    n_msgs     = 0;
    done       = 0;
    while (done < n_items) begin
      steady_flow = done inside {[n_items / 3 : n_items / 2]};
      // Most messages are well formed; the rest carry noise or stray padding.
      mode   = $urandom_range(0, 9);
      n_data = $urandom_range(1, 14);
      n_pad  = (mode < 7 && $urandom_range(0, 1)) ? (4 - n_data % 4) % 4 : 0;
      total  = n_data + n_pad;
      for (int i = 0; i < total; i++) begin
        if (i >= n_data) ch = CHAR_EQUAL;
        else if (mode == 9 && $urandom_range(0, 2) == 0) ch = CHAR_EQUAL;
        else if (mode >= 7 && $urandom_range(0, 3) == 0) ch = 8'($urandom_range(0, 255));
        else ch = pick_b64_char();
        send_char(ch, i == total - 1);
      end
      if (n_msgs == 0 || $urandom_range(0, 7) == 0) wait_drained();
      n_msgs++;
      done = chars_sent - first_char;
    end
    steady_flow = 1'b0;
  endtask

  always @(negedge clk) begin
    out_bus.ready = steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected: data_byte %0h byte_valid %0b", out_bus.data_byte,
               out_bus.byte_valid);
        fail_count++;
      end else begin
        want_word = expected_words.pop_front();
        check_field("data_byte", want_word.data_byte, out_bus.data_byte);
        check_field("byte_valid", 8'(want_word.byte_valid), 8'(out_bus.byte_valid));
        check_field("run_end", 8'(want_word.run_end), 8'(out_bus.run_end));
        check_field("end_of_message", 8'(want_word.end_of_message), 8'(out_bus.end_of_message));
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.text_char  = 8'h00;
    in_bus.final_char = 1'b0;
    out_bus.ready     = 1'b0;
    steady_flow       = 1'b0;
    fail_count        = 0;
    chars_sent        = 0;
    words_checked     = 0;
    messages_sent     = 0;
    stall_cycles      = 0;
    {grp_bits, grp_sextets, grp_pads} = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_alphabet_extremes();
    test_padding_rules();
    test_final_flush();
    test_random_messages(300);

    @(negedge clk);
    in_bus.valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Decoded %0d characters over %0d messages, both alphabets, padding and noise;",
             chars_sent, messages_sent);
    $display("%0d result words were compared field by field.", words_checked);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/b64ld_pkg.sv
src/b64ld_if.sv
src/b64ld_group.sv
src/b64ld_serializer.sv
src/base64_lenient_decoder.sv
tb/base64_lenient_decoder_tb.sv
